@@ hdl/inode_bitmap_allocator_core_macros.svh @@
// ============================================================================
// Inode bitmap allocator assertion macros
// Shared assertion wrappers for the checker of the inode bitmap allocator.
// ============================================================================
`ifndef INODE_BITMAP_ALLOCATOR_CORE_MACROS_SVH
`define INODE_BITMAP_ALLOCATOR_CORE_MACROS_SVH

// Concurrent assertion on a given clock, disabled while reset is low.
`define IBA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Same assertion on the block's own clock and reset names.
`define IBA_ASSERT_CORE(lbl, prop, msg) \
    `IBA_ASSERT(lbl, i_clk, i_rst_n, prop, msg)

`endif

@@ hdl/iba_pkg.sv @@
// ============================================================================
// Inode bitmap allocator package
// Sizes, codes, state type and shared structs of the inode bitmap allocator.
// ============================================================================
package iba_pkg;

    // Store geometry (powers of two).
    localparam int GROUPS          = 8;
    localparam int MAX_IPG         = 1024;
    localparam int WORD_BITS       = 64;
    localparam int WORDS_PER_GROUP = MAX_IPG / WORD_BITS;
    localparam int BITMAP_WORDS    = (GROUPS * MAX_IPG + WORD_BITS - 1) / WORD_BITS;

    // Field widths.
    localparam int OP_W     = 2;
    localparam int GRP_W    = 3;
    localparam int NUM_W    = 14;
    localparam int IPG_W    = 11;
    localparam int STAT_W   = 2;
    localparam int CFG_W    = 14;
    localparam int CFG_IDX_W = 1;

    // Derived widths.
    localparam int LOC_W  = $clog2(MAX_IPG);
    localparam int BIT_W  = $clog2(WORD_BITS);
    localparam int CW_W   = $clog2(WORDS_PER_GROUP);
    localparam int WIDX_W = $clog2(WORDS_PER_GROUP + 1);
    localparam int ADDR_W = GRP_W + CW_W;

    // Count saturation limits.
    localparam logic [IPG_W-1:0] GROUP_CNT_MAX = {IPG_W{1'b1}};
    localparam logic [NUM_W-1:0] TOTAL_CNT_MAX = {NUM_W{1'b1}};

    // Register reset values.
    localparam logic [IPG_W-1:0] IPG_RESET    = IPG_W'(MAX_IPG);
    localparam logic [NUM_W-1:0] ICOUNT_RESET = NUM_W'(GROUPS * MAX_IPG);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_IPG    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ICOUNT = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_TEST  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_BAD_INODE = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_BAD_GROUP = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ASETUP,
        S_SCAN,
        S_AWRITE,
        S_DIV,
        S_READ,
        S_MODIFY,
        S_DONE
    } t_state;

    // Result of the iterative divider.
    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quot;
        logic [LOC_W-1:0] rem;
    } t_div_res;

endpackage

@@ hdl/iba_if.sv @@
// ============================================================================
// Inode bitmap allocator channels
// Request and response channels with a valid and ready handshake.
// ============================================================================

// Request channel: one operation per transaction.
interface iba_req_if;
    logic                        valid;
    logic                        ready;
    logic [iba_pkg::OP_W-1:0]    op;
    logic [iba_pkg::GRP_W-1:0]   group;
    logic [iba_pkg::NUM_W-1:0]   inode_number;

    modport source (output valid, op, group, inode_number, input ready);
    modport sink   (input valid, op, group, inode_number, output ready);
endinterface

// Response channel: one result per transaction.
interface iba_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [iba_pkg::STAT_W-1:0]  status;
    logic [iba_pkg::NUM_W-1:0]   allocated_inode;
    logic                        in_use;
    logic [iba_pkg::IPG_W-1:0]   group_free;
    logic [iba_pkg::NUM_W-1:0]   total_free;

    modport source (output valid, status, allocated_inode, in_use, group_free, total_free,
                    input ready);
    modport sink   (input valid, status, allocated_inode, in_use, group_free, total_free,
                    output ready);
endinterface

@@ hdl/inode_bitmap_allocator_core.sv @@
// ============================================================================
// Inode bitmap allocator core
// Usage bitmap of all inodes in a RAM, with used counts per group and total.
// ============================================================================
// Usage: requests arrive on i_req (op, group, inode_number) and each gives
// exactly one response transaction on o_rsp. The two configuration
// registers are written through i_cfg_we / i_cfg_idx / i_cfg_data; the user
// must write them only while the block is idle, as the block itself leaves this unchecked.
// The block handles one request at a time. An allocate scans the group's
// bitmap words in a pipelined read loop, one RAM word per cycle, and stops
// at the first free inode; a group with no valid inodes is answered as full
// without a scan. A free or test runs the inode index through a serial
// divider; then a free does one RAM read-modify-write and a test one RAM
// read. A number past the last group is rejected after the divide. An
// invalid inode number and op 3 go straight to the final state.
// A finished result sits in the output register; the block accepts the next
// request while it waits, but a second result holds in the final state
// until the receiver takes the first.
// Reset clears the counts and a valid bit per bitmap word, so the whole
// bitmap reads as free at once with no clearing pass.
// ============================================================================
module inode_bitmap_allocator_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    iba_req_if.sink                          i_req,
    iba_rsp_if.source                        o_rsp,
    input  logic                             i_cfg_we,
    input  logic [iba_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [iba_pkg::CFG_W-1:0]        i_cfg_data
);

    localparam int NUM_W  = iba_pkg::NUM_W;
    localparam int IPG_W  = iba_pkg::IPG_W;
    localparam int GRP_W  = iba_pkg::GRP_W;
    localparam int LOC_W  = iba_pkg::LOC_W;
    localparam int BIT_W  = iba_pkg::BIT_W;
    localparam int CW_W   = iba_pkg::CW_W;
    localparam int WIDX_W = iba_pkg::WIDX_W;
    localparam int ADDR_W = iba_pkg::ADDR_W;
    localparam int WBITS  = iba_pkg::WORD_BITS;

    // Control state.
    iba_pkg::t_state              r_state, n_state;
    logic [IPG_W-1:0]             r_ipg;
    logic [NUM_W-1:0]             r_icount;
    logic [IPG_W-1:0]             r_gused [iba_pkg::GROUPS];
    logic [NUM_W-1:0]             r_tused;
    logic [iba_pkg::BITMAP_WORDS-1:0] r_wvalid;
    logic                         r_chk;
    logic                         r_out_valid;

    // Request and working registers.
    iba_pkg::t_op                 r_op;
    logic [GRP_W-1:0]             r_g;
    iba_pkg::t_status             r_status;
    logic [NUM_W-1:0]             r_alloc;
    logic                         r_in_use;
    logic                         r_gfree_en;
    logic [NUM_W-1:0]             r_base;
    logic [IPG_W-1:0]             r_limit;
    logic [WIDX_W-1:0]            r_nw;
    logic [WIDX_W-1:0]            r_widx;
    logic [CW_W-1:0]              r_cw;
    logic [LOC_W-1:0]             r_local;
    logic                         r_vq;
    logic [ADDR_W-1:0]            r_rdaddr_q;
    logic [ADDR_W-1:0]            r_waddr;
    logic [WBITS-1:0]             r_wdata;

    // Output registers.
    iba_pkg::t_status             r_o_status;
    logic [NUM_W-1:0]             r_o_alloc;
    logic                         r_o_in_use;
    logic [IPG_W-1:0]             r_o_gfree;
    logic [NUM_W-1:0]             r_o_tfree;

    // Combinational signals.
    logic [IPG_W-1:0]             w_ipg;
    logic                         w_accept;
    iba_pkg::t_op                 w_req_op;
    logic                         w_num_bad;
    logic                         w_grp_bad;
    logic [NUM_W-1:0]             w_base;
    logic [NUM_W-1:0]             w_span;
    logic [IPG_W-1:0]             w_limit;
    logic [IPG_W:0]               w_lim_round;
    logic [WIDX_W-1:0]            w_nw;
    logic [WBITS-1:0]             w_rd_data;
    logic [WBITS-1:0]             w_word;
    logic [LOC_W-1:0]             w_cw_base;
    logic [IPG_W-1:0]             w_wrem;
    logic [WBITS-1:0]             w_mask;
    logic [WBITS-1:0]             w_freev;
    logic                         w_found;
    logic [BIT_W-1:0]             w_fidx;
    logic [WBITS-1:0]             w_set_mask;
    logic [WBITS-1:0]             w_bit_mask;
    logic                         w_scan_full;
    logic                         w_rd_en;
    logic [ADDR_W-1:0]            w_rd_addr;
    logic                         w_we;
    logic [ADDR_W-1:0]            w_waddr;
    logic [WBITS-1:0]             w_wdata;
    logic                         w_div_start;
    logic                         w_load;
    iba_pkg::t_div_res            w_div;
    logic                         w_quot_bad;
    logic [IPG_W-1:0]             w_gused_sel;
    logic [IPG_W-1:0]             w_gfree;
    logic [NUM_W-1:0]             w_tfree;

    // Bitmap RAM.
    iba_ram #(
        .WIDTH (WBITS),
        .DEPTH (iba_pkg::BITMAP_WORDS)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_rd_en),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rd_data)
    );

    // Serial divider for inode index to group and local index.
    iba_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (i_req.inode_number - NUM_W'(1)),
        .i_divisor  (w_ipg),
        .o_res      (w_div)
    );

    // Effective inodes per group, clamped to 1 .. MAX_IPG.
    always_comb begin
        if (r_ipg == '0) begin
            w_ipg = IPG_W'(1);
        end else if (r_ipg > IPG_W'(iba_pkg::MAX_IPG)) begin
            w_ipg = IPG_W'(iba_pkg::MAX_IPG);
        end else begin
            w_ipg = r_ipg;
        end
    end

    // Request decode.
    always_comb begin
        w_accept  = i_req.valid && i_req.ready;
        w_req_op  = iba_pkg::t_op'(i_req.op);
        w_num_bad = (i_req.inode_number == '0) || (i_req.inode_number > r_icount);
        w_grp_bad = (int'(i_req.group) >= iba_pkg::GROUPS);
    end

    // Allocate setup: group base and the number of valid inodes in the group.
    always_comb begin
        w_base = NUM_W'(r_g) * NUM_W'(w_ipg);
        w_span = r_icount - w_base;
        if (r_icount <= w_base) begin
            w_limit = '0;
        end else if (w_span > NUM_W'(w_ipg)) begin
            w_limit = w_ipg;
        end else begin
            w_limit = w_span[IPG_W-1:0];
        end
        w_lim_round = {1'b0, w_limit} + (IPG_W + 1)'(WBITS - 1);
        w_nw        = w_lim_round[BIT_W +: WIDX_W];
    end

    // Scan: mask the word to valid local indexes and find the lowest clear bit.
    always_comb begin
        w_word    = r_vq ? w_rd_data : '0;
        w_cw_base = {r_cw, {BIT_W{1'b0}}};
        w_wrem    = r_limit - IPG_W'(w_cw_base);
        for (int b = 0; b < WBITS; b++) begin
            w_mask[b] = (w_wrem > IPG_W'(b));
        end
        w_freev = ~w_word & w_mask;
        w_found = |w_freev;
        w_fidx  = '0;
        for (int b = WBITS - 1; b >= 0; b--) begin
            if (w_freev[b]) begin
                w_fidx = BIT_W'(b);
            end
        end
        w_set_mask  = {{(WBITS - 1){1'b0}}, 1'b1} << w_fidx;
        w_bit_mask  = {{(WBITS - 1){1'b0}}, 1'b1} << r_local[BIT_W-1:0];
        w_scan_full = r_chk && !w_found && (r_widx == r_nw);
        w_quot_bad  = (w_div.quot >= NUM_W'(iba_pkg::GROUPS));
    end

    // Free counts of the affected group and of the whole store.
    always_comb begin
        w_gused_sel = r_gused[r_g];
        if (!r_gfree_en || (w_gused_sel >= w_ipg)) begin
            w_gfree = '0;
        end else begin
            w_gfree = w_ipg - w_gused_sel;
        end
        if (r_tused >= r_icount) begin
            w_tfree = '0;
        end else begin
            w_tfree = r_icount - r_tused;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            iba_pkg::S_IDLE: begin
                if (w_accept) begin
                    case (w_req_op)
                        iba_pkg::OP_ALLOC: n_state = w_grp_bad ? iba_pkg::S_DONE
                                                               : iba_pkg::S_ASETUP;
                        iba_pkg::OP_FREE,
                        iba_pkg::OP_TEST:  n_state = w_num_bad ? iba_pkg::S_DONE
                                                               : iba_pkg::S_DIV;
                        default:           n_state = iba_pkg::S_DONE;
                    endcase
                end
            end
            iba_pkg::S_ASETUP: begin
                n_state = (w_nw == '0) ? iba_pkg::S_DONE : iba_pkg::S_SCAN;
            end
            iba_pkg::S_SCAN: begin
                if (r_chk && w_found) begin
                    n_state = iba_pkg::S_AWRITE;
                end else if (w_scan_full) begin
                    n_state = iba_pkg::S_DONE;
                end
            end
            iba_pkg::S_AWRITE: n_state = iba_pkg::S_DONE;
            iba_pkg::S_DIV: begin
                if (w_div.done) begin
                    n_state = w_quot_bad ? iba_pkg::S_DONE : iba_pkg::S_READ;
                end
            end
            iba_pkg::S_READ:   n_state = iba_pkg::S_MODIFY;
            iba_pkg::S_MODIFY: n_state = iba_pkg::S_DONE;
            iba_pkg::S_DONE: begin
                if (w_load) begin
                    n_state = iba_pkg::S_IDLE;
                end
            end
            default: n_state = iba_pkg::S_IDLE;
        endcase
    end

    // State outputs: RAM ports, divider start, result load.
    always_comb begin
        w_rd_en     = 1'b0;
        w_rd_addr   = {r_g, r_local[LOC_W-1:BIT_W]};
        w_we        = 1'b0;
        w_waddr     = r_waddr;
        w_wdata     = r_wdata;
        w_div_start = 1'b0;
        w_load      = 1'b0;
        case (r_state)
            iba_pkg::S_IDLE: begin
                w_div_start = w_accept && !w_num_bad &&
                              ((w_req_op == iba_pkg::OP_FREE) ||
                               (w_req_op == iba_pkg::OP_TEST));
            end
            iba_pkg::S_SCAN: begin
                w_rd_addr = {r_g, r_widx[CW_W-1:0]};
                w_rd_en   = !(r_chk && w_found) && (r_widx < r_nw);
            end
            iba_pkg::S_AWRITE: begin
                w_we = 1'b1;
            end
            iba_pkg::S_READ: begin
                w_rd_en = 1'b1;
            end
            iba_pkg::S_MODIFY: begin
                w_waddr = r_rdaddr_q;
                w_wdata = w_word & ~w_bit_mask;
                w_we    = (r_op == iba_pkg::OP_FREE);
            end
            iba_pkg::S_DONE: begin
                w_load = !r_out_valid || o_rsp.ready;
            end
            default: begin
                w_load = 1'b0;
            end
        endcase
    end

    // Control registers, configuration, counts and word valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= iba_pkg::S_IDLE;
            r_ipg       <= iba_pkg::IPG_RESET;
            r_icount    <= iba_pkg::ICOUNT_RESET;
            for (int g = 0; g < iba_pkg::GROUPS; g++) begin
                r_gused[g] <= '0;
            end
            r_tused     <= '0;
            r_wvalid    <= '0;
            r_chk       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_chk   <= w_rd_en && (r_state == iba_pkg::S_SCAN);

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    iba_pkg::CFG_IPG:    r_ipg    <= i_cfg_data[IPG_W-1:0];
                    iba_pkg::CFG_ICOUNT: r_icount <= i_cfg_data[NUM_W-1:0];
                    default:             r_ipg    <= r_ipg;
                endcase
            end

            if (w_we) begin
                r_wvalid[w_waddr] <= 1'b1;
            end

            // Allocation raises the counts, a free lowers them, both saturating.
            if (r_state == iba_pkg::S_AWRITE) begin
                if (r_gused[r_g] < iba_pkg::GROUP_CNT_MAX) begin
                    r_gused[r_g] <= r_gused[r_g] + IPG_W'(1);
                end
                if (r_tused < iba_pkg::TOTAL_CNT_MAX) begin
                    r_tused <= r_tused + NUM_W'(1);
                end
            end else if ((r_state == iba_pkg::S_MODIFY) && (r_op == iba_pkg::OP_FREE)) begin
                if (r_gused[r_g] != '0) begin
                    r_gused[r_g] <= r_gused[r_g] - IPG_W'(1);
                end
                if (r_tused != '0) begin
                    r_tused <= r_tused - NUM_W'(1);
                end
            end

            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers of the current request.
    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_vq       <= r_wvalid[w_rd_addr];
            r_rdaddr_q <= w_rd_addr;
        end
        case (r_state)
            iba_pkg::S_IDLE: begin
                if (w_accept) begin
                    r_op       <= w_req_op;
                    r_g        <= i_req.group;
                    r_alloc    <= '0;
                    r_in_use   <= 1'b0;
                    r_gfree_en <= (w_req_op == iba_pkg::OP_ALLOC) && !w_grp_bad;
                    if ((w_req_op == iba_pkg::OP_ALLOC) && w_grp_bad) begin
                        r_status <= iba_pkg::STAT_BAD_GROUP;
                    end else if (((w_req_op == iba_pkg::OP_FREE) ||
                                  (w_req_op == iba_pkg::OP_TEST)) && w_num_bad) begin
                        r_status <= iba_pkg::STAT_BAD_INODE;
                    end else begin
                        r_status <= iba_pkg::STAT_OK;
                    end
                end
            end
            iba_pkg::S_ASETUP: begin
                r_base  <= w_base;
                r_limit <= w_limit;
                r_nw    <= w_nw;
                r_widx  <= '0;
                if (w_nw == '0) begin
                    r_status <= iba_pkg::STAT_FULL;
                end
            end
            iba_pkg::S_SCAN: begin
                if (w_rd_en) begin
                    r_widx <= r_widx + WIDX_W'(1);
                    r_cw   <= r_widx[CW_W-1:0];
                end
                if (r_chk && w_found) begin
                    r_wdata <= w_word | w_set_mask;
                    r_waddr <= r_rdaddr_q;
                    r_local <= {r_cw, w_fidx};
                end
                if (w_scan_full) begin
                    r_status <= iba_pkg::STAT_FULL;
                end
            end
            iba_pkg::S_AWRITE: begin
                r_alloc <= r_base + NUM_W'(r_local) + NUM_W'(1);
            end
            iba_pkg::S_DIV: begin
                if (w_div.done) begin
                    if (w_quot_bad) begin
                        r_status <= iba_pkg::STAT_BAD_INODE;
                    end else begin
                        r_g        <= w_div.quot[GRP_W-1:0];
                        r_local    <= w_div.rem;
                        r_gfree_en <= 1'b1;
                    end
                end
            end
            iba_pkg::S_MODIFY: begin
                if (r_op == iba_pkg::OP_TEST) begin
                    r_in_use <= w_word[r_local[BIT_W-1:0]];
                end
            end
            iba_pkg::S_DONE: begin
                if (w_load) begin
                    r_o_status <= r_status;
                    r_o_alloc  <= r_alloc;
                    r_o_in_use <= r_in_use;
                    r_o_gfree  <= w_gfree;
                    r_o_tfree  <= w_tfree;
                end
            end
            default: begin
            end
        endcase
    end

    // Channel outputs.
    assign i_req.ready           = (r_state == iba_pkg::S_IDLE);
    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.status          = r_o_status;
    assign o_rsp.allocated_inode = r_o_alloc;
    assign o_rsp.in_use          = r_o_in_use;
    assign o_rsp.group_free      = r_o_gfree;
    assign o_rsp.total_free      = r_o_tfree;

endmodule

@@ hdl/iba_ram.sv @@
// ============================================================================
// Generic RAM
// Simple dual-port RAM with one write port and one registered read port.
// ============================================================================
module iba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/iba_div.sv @@
// ============================================================================
// Inode index divider
// Restoring divider that splits an inode index into group and local index,
// one quotient bit per cycle.
// ============================================================================
module iba_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [iba_pkg::NUM_W-1:0]    i_dividend,
    input  logic [iba_pkg::IPG_W-1:0]    i_divisor,
    output iba_pkg::t_div_res            o_res
);

    localparam int CNT_W = $clog2(iba_pkg::NUM_W);

    logic                        r_busy;
    logic                        r_done;
    logic [CNT_W-1:0]            r_cnt;
    logic [iba_pkg::NUM_W-1:0]   r_quot;
    logic [iba_pkg::IPG_W-1:0]   r_rem;
    logic [iba_pkg::IPG_W-1:0]   r_dvs;

    logic [iba_pkg::IPG_W:0]     w_trial;
    logic                        w_fits;
    logic [iba_pkg::IPG_W:0]     w_diff;

    // One trial subtraction per step.
    always_comb begin
        w_trial = {r_rem, r_quot[iba_pkg::NUM_W-1]};
        w_fits  = (w_trial >= {1'b0, r_dvs});
        w_diff  = w_trial - {1'b0, r_dvs};
    end

    // Control: busy for one cycle per quotient bit, done pulses at the end.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(iba_pkg::NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: the dividend shifts out as the quotient shifts in.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[iba_pkg::NUM_W-2:0], w_fits};
            r_rem  <= w_fits ? w_diff[iba_pkg::IPG_W-1:0] : w_trial[iba_pkg::IPG_W-1:0];
        end
    end

    assign o_res.done = r_done;
    assign o_res.quot = r_quot;
    assign o_res.rem  = r_rem[iba_pkg::LOC_W-1:0];

endmodule

@@ hdl/iba_checker.sv @@
// ============================================================================
// Inode bitmap allocator checker
// Port-level assertions on the request and response channels of the core.
// ============================================================================
`include "inode_bitmap_allocator_core_macros.svh"

module iba_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_req_valid,
    input logic                           i_req_ready,
    input logic                           o_rsp_valid,
    input logic                           o_rsp_ready,
    input logic [iba_pkg::STAT_W-1:0]     o_rsp_status,
    input logic [iba_pkg::NUM_W-1:0]      o_rsp_allocated_inode,
    input logic                           o_rsp_in_use,
    input logic [iba_pkg::IPG_W-1:0]      o_rsp_group_free
);

    // A pending result stays until the receiver takes it.
    `IBA_ASSERT_CORE(a_rsp_hold, o_rsp_valid && !o_rsp_ready |=> o_rsp_valid, "response dropped")

    // The block works on one request at a time.
    `IBA_ASSERT_CORE(a_one_at_a_time, i_req_valid && i_req_ready |=> !i_req_ready, "overlapping requests")

    // A rejected or full request grants no inode and reports no usage bit.
    `IBA_ASSERT_CORE(a_reject_clean, o_rsp_valid && (o_rsp_status != iba_pkg::STAT_OK) |-> (o_rsp_allocated_inode == '0) && !o_rsp_in_use, "rejected request carries data")

    // An invalid number or group leaves no group to report on.
    `IBA_ASSERT_CORE(a_invalid_no_group, o_rsp_valid && ((o_rsp_status == iba_pkg::STAT_BAD_INODE) || (o_rsp_status == iba_pkg::STAT_BAD_GROUP)) |-> (o_rsp_group_free == '0), "group free on invalid request")

endmodule

bind inode_bitmap_allocator_core iba_checker u_iba_checker (
    .i_clk                 (i_clk),
    .i_rst_n               (i_rst_n),
    .i_req_valid           (i_req.valid),
    .i_req_ready           (i_req.ready),
    .o_rsp_valid           (o_rsp.valid),
    .o_rsp_ready           (o_rsp.ready),
    .o_rsp_status          (o_rsp.status),
    .o_rsp_allocated_inode (o_rsp.allocated_inode),
    .o_rsp_in_use          (o_rsp.in_use),
    .o_rsp_group_free      (o_rsp.group_free)
);
